// File: sv/csb_pkg.sv
package csb_pkg;

	localparam int CW = 18;

	typedef logic signed [CW-1:0] coord_t;

	localparam int DEF_MAX_SPRITE_W = 8;
	localparam int DEF_MAX_SPRITE_H = 8;
	localparam int DEF_X_LIMIT      = 64;
	localparam int DEF_Y_LIMIT      = 128;

	localparam int STORE_DEPTH = 8;

	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_ABS  = 2'd1;
	localparam logic [1:0] MODE_OFS  = 2'd2;
	localparam logic [1:0] MODE_RECT = 2'd3;

	localparam logic [1:0] REG_SPRITE_W  = 2'd0;
	localparam logic [1:0] REG_SPRITE_H  = 2'd1;
	localparam logic [1:0] REG_SPRITE_BX = 2'd2;
	localparam logic [1:0] REG_SPRITE_BY = 2'd3;

	localparam logic [3:0] RECT_MAX = 4'd8;

	typedef struct packed {
		coord_t sum;
		logic   vis;
		coord_t clamped;
	} axis_res_t;

endpackage

// File: sv/clipped_sprite_blitter_unit.sv
// Load, and a draw or fill of zero size: taken while idle, no result.
// Draw and fill: an origin step and a bound step on the shared adders, then one pixel of the
// w by h grid (up to 64) per cycle while the output does not stall, column by column; the
// first write is registered during the walk, after both steps. The next command waits.
// Reset clears control state and the registers to their defaults; image bytes
// are undefined until loaded.
module clipped_sprite_blitter_unit import csb_pkg::*; #(
	parameter int MAX_SPRITE_W = DEF_MAX_SPRITE_W,
	parameter int MAX_SPRITE_H = DEF_MAX_SPRITE_H,
	parameter int X_LIMIT      = DEF_X_LIMIT,
	parameter int Y_LIMIT      = DEF_Y_LIMIT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [2:0]         byte_index,
	input  logic [7:0]         byte_value,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic [3:0]         rect_w,
	input  logic [3:0]         rect_h,
	input  logic               fill_color,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [5:0]         pixel_x,
	output logic [6:0]         pixel_y,
	output logic               pixel_on,
	output logic               last_write,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_ORIGIN = 2'd1;
	localparam logic [1:0] ST_BOUND  = 2'd2;
	localparam logic [1:0] ST_WALK   = 2'd3;

	localparam logic [3:0] MAXW = 4'(MAX_SPRITE_W);
	localparam logic [3:0] MAXH = 4'(MAX_SPRITE_H);

	logic [1:0] state_q;
	logic [1:0] mode_q;
	logic       color_q;
	logic [3:0] w_q, h_q;
	logic [3:0] col_q, row_q;
	coord_t     posx_q, posy_q;
	coord_t     ox_q, oy_q;
	coord_t     lastx_q, lasty_q;
	logic [7:0] store_q [STORE_DEPTH];

	logic [3:0] sprite_w_q, sprite_h_q;
	logic [7:0] base_x_q, base_y_q;

	logic       out_valid_q;
	logic [5:0] pixel_x_q;
	logic [6:0] pixel_y_q;
	logic       pixel_on_q;
	logic       last_q;

	coord_t     ax_a, ax_b, ay_a, ay_b;
	axis_res_t  rx, ry;

	logic       in_acc, adv, col_end, row_end, pix_set;
	logic [3:0] cmd_w, cmd_h;
	logic [7:0] row_byte;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign adv       = !out_valid_q || !out_stall;
	assign col_end   = (col_q == w_q - 4'd1);
	assign row_end   = (row_q == h_q - 4'd1);
	assign cfg_ready = 1'b1;

	assign out_valid  = out_valid_q;
	assign pixel_x    = pixel_x_q;
	assign pixel_y    = pixel_y_q;
	assign pixel_on   = pixel_on_q;
	assign last_write = last_q;

	always_comb begin
		if (mode == MODE_RECT) begin
			cmd_w = (rect_w > RECT_MAX) ? RECT_MAX : rect_w;
			cmd_h = (rect_h > RECT_MAX) ? RECT_MAX : rect_h;
		end else begin
			cmd_w = (sprite_w_q > MAXW) ? MAXW : sprite_w_q;
			cmd_h = (sprite_h_q > MAXH) ? MAXH : sprite_h_q;
		end
	end

	always_comb begin
		case (state_q)
			ST_ORIGIN: begin
				ax_a = posx_q;
				ay_a = posy_q;
				ax_b = (mode_q == MODE_OFS) ? coord_t'({1'b0, base_x_q}) : '0;
				ay_b = (mode_q == MODE_OFS) ? coord_t'({1'b0, base_y_q}) : '0;
			end
			ST_BOUND: begin
				ax_a = ox_q;
				ay_a = oy_q;
				ax_b = coord_t'({1'b0, w_q - 4'd1});
				ay_b = coord_t'({1'b0, h_q - 4'd1});
			end
			default: begin
				ax_a = ox_q;
				ay_a = oy_q;
				ax_b = coord_t'({1'b0, col_q});
				ay_b = coord_t'({1'b0, row_q});
			end
		endcase
	end

	csb_axis_unit #(.LIMIT(X_LIMIT)) u_axis_x (.a(ax_a), .b(ax_b), .res(rx));
	csb_axis_unit #(.LIMIT(Y_LIMIT)) u_axis_y (.a(ay_a), .b(ay_b), .res(ry));

	assign row_byte = store_q[row_q[2:0]];
	assign pix_set  = |(row_byte & (8'h80 >> col_q[2:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && mode != MODE_LOAD && cmd_w != 4'd0 && cmd_h != 4'd0)
						state_q <= ST_ORIGIN;
				end
				ST_ORIGIN: state_q <= ST_BOUND;
				ST_BOUND:  state_q <= ST_WALK;
				ST_WALK: begin
					if (adv) begin
						if (row_end) begin
							row_q <= '0;
							if (col_end) begin
								col_q   <= '0;
								state_q <= ST_IDLE;
							end else begin
								col_q <= col_q + 4'd1;
							end
						end else begin
							row_q <= row_q + 4'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q  <= mode;
			color_q <= fill_color;
			w_q     <= cmd_w;
			h_q     <= cmd_h;
			posx_q  <= coord_t'(pos_x);
			posy_q  <= coord_t'(pos_y);
			if (mode == MODE_LOAD)
				store_q[byte_index] <= byte_value;
		end
		if (state_q == ST_ORIGIN) begin
			ox_q <= rx.sum;
			oy_q <= ry.sum;
		end
		if (state_q == ST_BOUND) begin
			lastx_q <= rx.clamped;
			lasty_q <= ry.clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sprite_w_q <= 4'd8;
			sprite_h_q <= 4'd8;
			base_x_q   <= '0;
			base_y_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SPRITE_W:  sprite_w_q <= cfg_data[3:0];
				REG_SPRITE_H:  sprite_h_q <= cfg_data[3:0];
				REG_SPRITE_BX: base_x_q   <= cfg_data;
				REG_SPRITE_BY: base_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_WALK && adv && rx.vis && ry.vis) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WALK && adv && rx.vis && ry.vis) begin
			pixel_x_q  <= rx.sum[5:0];
			pixel_y_q  <= ry.sum[6:0];
			pixel_on_q <= (mode_q == MODE_RECT) ? color_q : pix_set;
			last_q     <= (rx.sum == lastx_q) && (ry.sum == lasty_q);
		end
	end

	a_idle_counters: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (col_q == 4'd0 && row_q == 4'd0))
		else $error("walk counters not cleared in idle");

	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (col_q < w_q && row_q < h_q))
		else $error("walk counters beyond command size");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=>
		(out_valid_q && $stable({pixel_x_q, pixel_y_q, pixel_on_q, last_q})))
		else $error("stalled pixel transfer changed");

endmodule

// File: sv/csb_axis_unit.sv
module csb_axis_unit import csb_pkg::*; #(
	parameter int LIMIT = DEF_X_LIMIT
) (
	input  coord_t    a,
	input  coord_t    b,
	output axis_res_t res
);

	localparam coord_t LIM     = coord_t'(LIMIT);
	localparam coord_t LIM_TOP = coord_t'(LIMIT - 1);

	coord_t sum;

	assign sum         = a + b;
	assign res.sum     = sum;
	assign res.vis     = (sum >= 0) && (sum < LIM);
	assign res.clamped = (sum > LIM_TOP) ? LIM_TOP : sum;

endmodule
